@@ rtl/fmpd_pkg.sv @@
`default_nettype none

package fmpd_pkg;

  // event opcodes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_PULSE = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;
  localparam logic [1:0] OP_STOP  = 2'd3;

  // end reasons
  localparam logic [2:0] RSN_NONE    = 3'd0;
  localparam logic [2:0] RSN_TARGET  = 3'd1;
  localparam logic [2:0] RSN_MANUAL  = 3'd2;
  localparam logic [2:0] RSN_NO_FLOW = 3'd3;
  localparam logic [2:0] RSN_MAX_RUN = 3'd4;
  localparam logic [2:0] RSN_ZERO    = 3'd5;

  // register map, index taken from paddr[3:2]
  localparam int          APB_AW      = 4;
  localparam logic [1:0]  REG_WINDOW  = 2'd0;
  localparam logic [1:0]  REG_NO_FLOW = 2'd1;
  localparam logic [1:0]  REG_MAX_RUN = 2'd2;
  localparam logic [1:0]  REG_RATE    = 2'd3;

  // register reset values
  localparam logic [9:0]  WINDOW_RST  = 10'd100;
  localparam logic [15:0] NO_FLOW_RST = 16'd5000;
  localparam logic [23:0] MAX_RUN_RST = 24'd600000;
  localparam logic [15:0] RATE_RST    = 16'd46976;

  // fixed limits of the millisecond counters
  localparam logic [23:0] MS24_MAX   = 24'hFFFFFF;
  localparam logic [16:0] NOFLOW_MAX = 17'h1FFFF;

  typedef logic [1:0]  opcode_t;
  typedef logic [15:0] volume_t;
  typedef logic [23:0] count24_t;
  typedef logic [2:0]  reason_t;

endpackage

`default_nettype wire

@@ rtl/fmpd_if.sv @@
`default_nettype none

interface fmpd_in_if;
  logic              valid;
  logic              ready;
  fmpd_pkg::opcode_t opcode;
  fmpd_pkg::volume_t volume;

  modport source (output valid, output opcode, output volume, input ready);
  modport sink   (input valid, input opcode, input volume, output ready);
endinterface

interface fmpd_out_if;
  logic               valid;
  logic               ready;
  logic               pump_on;
  fmpd_pkg::count24_t pulses_counted;
  fmpd_pkg::count24_t pulse_target;
  logic               finished;
  fmpd_pkg::reason_t  end_reason;

  modport source (output valid, output pump_on, output pulses_counted, output pulse_target,
                  output finished, output end_reason, input ready);
  modport sink   (input valid, input pump_on, input pulses_counted, input pulse_target,
                  input finished, input end_reason, output ready);
endinterface

`default_nettype wire

@@ rtl/flow_metered_pump_dosing.sv @@
// a word accepted into the input register moves on into the result register when the
//   latter is empty or being drained; one event per cycle while the output is not stalled
// the input register feeds one short pass of
//   logic (16x16 rate multiply on start, counter updates otherwise) into the result register
// reset: synchronous active-low rst_n stops the pump, clears run state and both
//   pipeline valids, and loads the registers with their documented defaults
`default_nettype none

module flow_metered_pump_dosing #(
  parameter int COUNT_WIDTH = 24
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  fmpd_in_if.sink                          in_ch,
  fmpd_out_if.source                       out_ch,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [fmpd_pkg::APB_AW-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready
);

  import fmpd_pkg::*;

  // saturation limit of the pulse counter and target, also in 33-bit form for
  // comparison against the rounded product
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX   = '1;
  localparam logic [32:0]            CNT_MAX33 = 33'((64'd1 << COUNT_WIDTH) - 64'd1);

  // ---------------------------------------------------------------------------
  // configuration registers, apb write on the access phase
  // ---------------------------------------------------------------------------
  logic [9:0]  window_r;
  logic [15:0] timeout_r;
  logic [23:0] max_run_r;
  logic [15:0] rate_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r  <= WINDOW_RST;
      timeout_r <= NO_FLOW_RST;
      max_run_r <= MAX_RUN_RST;
      rate_r    <= RATE_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_WINDOW:  window_r  <= pwdata[9:0];
        REG_NO_FLOW: timeout_r <= pwdata[15:0];
        REG_MAX_RUN: max_run_r <= pwdata[23:0];
        REG_RATE:    rate_r    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read back, zero-extended to the bus
  always_comb begin
    case (paddr[3:2])
      REG_WINDOW:  prdata = {22'd0, window_r};
      REG_NO_FLOW: prdata = {16'd0, timeout_r};
      REG_MAX_RUN: prdata = {8'd0, max_run_r};
      REG_RATE:    prdata = {16'd0, rate_r};
      default:     prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // pipeline handshake
  // the result register advances when it is empty or being drained; the input
  // register takes a new word when it is empty or its content moves on in the same cycle
  // ---------------------------------------------------------------------------
  logic    s1_valid_r;
  opcode_t s1_op_r;
  volume_t s1_vol_r;
  logic    out_valid_r;
  logic    advance;
  logic    step_en;

  assign advance     = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || advance;
  assign step_en     = s1_valid_r && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_op_r  <= in_ch.opcode;
      s1_vol_r <= in_ch.volume;
    end
  end

  // ---------------------------------------------------------------------------
  // run state
  // ---------------------------------------------------------------------------
  logic                   running_r,  running_nxt;
  logic [COUNT_WIDTH-1:0] pulses_r,   pulses_nxt;
  logic [COUNT_WIDTH-1:0] target_r,   target_nxt;
  logic [23:0]            elapsed_r,  elapsed_nxt;
  logic [9:0]             win_cnt_r,  win_cnt_nxt;
  logic                   pulse_seen_r, pulse_seen_nxt;
  logic [16:0]            no_flow_r,  no_flow_nxt;
  reason_t                reason_r,   reason_nxt;
  logic                   fin;

  // start: target = round(volume * rate / 256), at least one, saturated
  logic [31:0]            prod;
  logic [32:0]            rounded;
  logic [32:0]            t33;
  logic [COUNT_WIDTH-1:0] start_target;

  assign prod    = {16'd0, s1_vol_r} * {16'd0, rate_r};
  assign rounded = {1'b0, prod} + 33'd128;
  assign t33     = {8'd0, rounded[32:8]};

  always_comb begin
    if (t33 == 33'd0) begin
      start_target = COUNT_WIDTH'(1);
    end else if (t33 > CNT_MAX33) begin
      start_target = CNT_MAX;
    end else begin
      start_target = t33[COUNT_WIDTH-1:0];
    end
  end

  // pulse: saturating count
  logic [COUNT_WIDTH-1:0] pulses_inc;
  assign pulses_inc = (pulses_r != CNT_MAX) ? pulses_r + COUNT_WIDTH'(1) : pulses_r;

  // tick: a zero window length behaves as one millisecond
  logic [9:0]  win_len;
  logic [23:0] elapsed_inc;
  logic [10:0] win_cnt_inc;
  logic        win_end;
  logic [17:0] no_flow_sum;
  logic [16:0] no_flow_add;
  logic [16:0] no_flow_new;
  logic        stop_no_flow;
  logic        stop_max_run;

  assign win_len      = (window_r == 10'd0) ? 10'd1 : window_r;
  assign elapsed_inc  = (elapsed_r != MS24_MAX) ? elapsed_r + 24'd1 : elapsed_r;
  assign win_cnt_inc  = {1'b0, win_cnt_r} + 11'd1;
  assign win_end      = win_cnt_inc >= {1'b0, win_len};
  assign no_flow_sum  = {1'b0, no_flow_r} + {8'd0, win_len};
  assign no_flow_add  = no_flow_sum[17] ? NOFLOW_MAX : no_flow_sum[16:0];
  assign no_flow_new  = pulse_seen_r ? 17'd0 : no_flow_add;
  // no-flow is checked first and so wins when both limits meet at one window end
  assign stop_no_flow = (no_flow_new != 17'd0) && (no_flow_new >= {1'b0, timeout_r});
  assign stop_max_run = elapsed_inc > max_run_r;

  always_comb begin
    running_nxt    = running_r;
    pulses_nxt     = pulses_r;
    target_nxt     = target_r;
    elapsed_nxt    = elapsed_r;
    win_cnt_nxt    = win_cnt_r;
    pulse_seen_nxt = pulse_seen_r;
    no_flow_nxt    = no_flow_r;
    reason_nxt     = reason_r;
    fin            = 1'b0;

    case (s1_op_r)
      OP_START: begin
        // a start while running is ignored, zero volume included
        if (!running_r) begin
          if (s1_vol_r == 16'd0) begin
            reason_nxt = RSN_ZERO;
            fin        = 1'b1;
          end else begin
            target_nxt     = start_target;
            pulses_nxt     = '0;
            elapsed_nxt    = 24'd0;
            win_cnt_nxt    = 10'd0;
            pulse_seen_nxt = 1'b0;
            no_flow_nxt    = 17'd0;
            reason_nxt     = RSN_NONE;
            running_nxt    = 1'b1;
          end
        end
      end
      OP_STOP: begin
        if (running_r) begin
          running_nxt = 1'b0;
          reason_nxt  = RSN_MANUAL;
          fin         = 1'b1;
        end
      end
      OP_PULSE: begin
        // target checked on every pulse, not only at window ends
        if (running_r) begin
          pulses_nxt     = pulses_inc;
          pulse_seen_nxt = 1'b1;
          if (pulses_inc >= target_r) begin
            running_nxt = 1'b0;
            reason_nxt  = RSN_TARGET;
            fin         = 1'b1;
          end
        end
      end
      OP_TICK: begin
        if (running_r) begin
          elapsed_nxt = elapsed_inc;
          win_cnt_nxt = win_cnt_inc[9:0];
          if (win_end) begin
            win_cnt_nxt    = 10'd0;
            no_flow_nxt    = no_flow_new;
            pulse_seen_nxt = 1'b0;
            if (stop_no_flow) begin
              running_nxt = 1'b0;
              reason_nxt  = RSN_NO_FLOW;
              fin         = 1'b1;
            end else if (stop_max_run) begin
              running_nxt = 1'b0;
              reason_nxt  = RSN_MAX_RUN;
              fin         = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r    <= 1'b0;
      pulses_r     <= '0;
      target_r     <= '0;
      elapsed_r    <= 24'd0;
      win_cnt_r    <= 10'd0;
      pulse_seen_r <= 1'b0;
      no_flow_r    <= 17'd0;
      reason_r     <= RSN_NONE;
    end else if (step_en) begin
      running_r    <= running_nxt;
      pulses_r     <= pulses_nxt;
      target_r     <= target_nxt;
      elapsed_r    <= elapsed_nxt;
      win_cnt_r    <= win_cnt_nxt;
      pulse_seen_r <= pulse_seen_nxt;
      no_flow_r    <= no_flow_nxt;
      reason_r     <= reason_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // result register; counters are shown through a 32-bit view and cut to the
  // 24-bit fields
  // ---------------------------------------------------------------------------
  logic [31:0] pulses_view;
  logic [31:0] target_view;
  logic        res_pump_r;
  count24_t    res_pulses_r;
  count24_t    res_target_r;
  logic        res_fin_r;
  reason_t     res_reason_r;

  assign pulses_view = 32'(pulses_nxt);
  assign target_view = 32'(target_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_en) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      res_pump_r   <= running_nxt;
      res_pulses_r <= pulses_view[23:0];
      res_target_r <= target_view[23:0];
      res_fin_r    <= fin;
      res_reason_r <= reason_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.pump_on        = res_pump_r;
  assign out_ch.pulses_counted = res_pulses_r;
  assign out_ch.pulse_target   = res_target_r;
  assign out_ch.finished       = res_fin_r;
  assign out_ch.end_reason     = res_reason_r;

endmodule

`default_nettype wire
